>>> rtl/voted_strip_odometer_core_macros.svh
// ----------------------------------------------------------------------------
// Voted strip odometer assertion macros
// Shared concurrent assertion forms used by the odometer RTL.
// ----------------------------------------------------------------------------
`ifndef VOTED_STRIP_ODOMETER_CORE_MACROS_SVH
`define VOTED_STRIP_ODOMETER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define VSO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VSO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voted strip odometer package
// Widths, constants, vote codes and divider interface types.
// ----------------------------------------------------------------------------
package vso_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int INTERVAL_BITS = 16;

    localparam int SPACING_W = 16;
    localparam int AGREED_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 32;
    localparam int VEL_W     = 26;
    localparam int ACC_W     = 27;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd3048;
    localparam int MS_PER_S = 1000;

    // Sum of up to three intervals.
    localparam int SUM_W = INTERVAL_BITS + 2;

    localparam int DIV_CNT_W = $clog2(VEL_W + 1);

    typedef enum logic [STATUS_W-1:0] {
        VOTE_ALL   = 3'd0,
        VOTE_OUT_A = 3'd1,
        VOTE_OUT_B = 3'd2,
        VOTE_OUT_C = 3'd3,
        VOTE_NONE  = 3'd4
    } vote_status_t;

    typedef struct packed {
        logic                     start;
        logic [VEL_W-1:0]         dividend;
        logic [INTERVAL_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/vso_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voted strip odometer divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "voted_strip_odometer_core_macros.svh"

module vso_div
    import vso_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic [DIV_CNT_W-1:0]     cnt_next;
    logic [VEL_W-1:0]         quo_reg;
    logic [VEL_W-1:0]         quo_next;
    logic [INTERVAL_BITS-1:0] rem_reg;
    logic [INTERVAL_BITS-1:0] rem_next;
    logic [INTERVAL_BITS-1:0] dvs_reg;
    logic [INTERVAL_BITS-1:0] dvs_next;
    logic [INTERVAL_BITS:0]   trial;
    logic [INTERVAL_BITS:0]   trial_sub;
    logic                     trial_ge;

    assign trial     = {rem_reg, quo_reg[VEL_W-1]};
    assign trial_ge  = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(VEL_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VEL_W-2:0], trial_ge};
            rem_next = trial_ge ? trial_sub[INTERVAL_BITS-1:0] : trial[INTERVAL_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `VSO_ASSERT_NOW(a_div_start_idle, req.start, !busy_reg, "divider restarted while busy")
    `VSO_ASSERT_NEXT(a_div_done_after_busy, busy_reg && (cnt_reg == DIV_CNT_W'(1)) && !req.start, done_reg && !busy_reg, "divider did not finish after its last step")

endmodule

>>> rtl/voted_strip_odometer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voted strip odometer core
// Votes three redundant strip sensors and derives position, velocity and
// acceleration with one shared multiplier and one shared serial divider.
// ----------------------------------------------------------------------------
// Channel   | Signals                         | Content
// s_*       | s_tvalid s_tready s_tdata       | three counts, three intervals
// m_*       | m_tvalid m_tready m_tdata m_tuser | count, position, motion, vote
// cfg_*     | cfg_we cfg_wdata                | strip spacing in centimetres
//
// A request runs the position product, the averaging product when all three
// sensors agree, the velocity product and two passes of the 26-step divider,
// for velocity and then acceleration; without agreement or with a zero interval
// it skips to the output step. Reset is asynchronous and restores the spacing
// to 3048 cm and the previous velocity to zero. A finished result waits in the
// output register while the next request is taken; a full one stalls.
// ----------------------------------------------------------------------------
`include "voted_strip_odometer_core_macros.svh"

module voted_strip_odometer_core
    import vso_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SPACING_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // count_a, count_b, count_c, interval_a, interval_b, interval_c
    input  logic [((3 * COUNT_BITS + 3 * INTERVAL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // agreed_count, position_cm, velocity_cm_s, accel_cm_s2
    output logic [((AGREED_W + POS_W + VEL_W + ACC_W + 7) / 8) * 8 - 1:0] m_tdata,
    // vote_status, motion_valid
    output logic [STATUS_W:0]    m_tuser
);

    localparam int IN_INT_OFS  = 3 * COUNT_BITS;
    localparam int OUT_DATA_W  = ((AGREED_W + POS_W + VEL_W + ACC_W + 7) / 8) * 8;
    localparam int CNT_EXT_W   = (COUNT_BITS > AGREED_W) ? COUNT_BITS : AGREED_W;
    localparam int MA_W_0      = (COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W;
    localparam int MA_W        = (MA_W_0 > SPACING_W) ? MA_W_0 : SPACING_W;
    localparam int MB_W        = (SUM_W > SPACING_W) ? SUM_W : SPACING_W;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int RECIP3_SHIFT = SUM_W + 1;
    localparam longint unsigned RECIP3_FULL =
        ((64'd1 << RECIP3_SHIFT) + 64'd2) / 64'd3;
    localparam logic [SUM_W-1:0] RECIP3 = SUM_W'(RECIP3_FULL);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MUL_POS = 8'b0000_0010,
        ST_MUL_AVG = 8'b0000_0100,
        ST_MUL_VEL = 8'b0000_1000,
        ST_DIV_VEL = 8'b0001_0000,
        ST_DIFF    = 8'b0010_0000,
        ST_DIV_ACC = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [SPACING_W-1:0]     spacing_reg;
    logic [VEL_W-1:0]         last_vel_reg;
    logic [VEL_W-1:0]         last_vel_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;

    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    vote_status_t             status_reg;
    vote_status_t             status_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [INTERVAL_BITS-1:0] interval_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [VEL_W-1:0]         vel_reg;
    logic [VEL_W-1:0]         vel_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     motion_reg;
    logic                     motion_next;
    logic                     neg_reg;
    logic                     neg_next;

    logic [AGREED_W-1:0]      out_count_reg;
    logic [AGREED_W-1:0]      out_count_next;
    vote_status_t             out_status_reg;
    vote_status_t             out_status_next;
    logic [POS_W-1:0]         out_pos_reg;
    logic [POS_W-1:0]         out_pos_next;
    logic [VEL_W-1:0]         out_vel_reg;
    logic [VEL_W-1:0]         out_vel_next;
    logic signed [ACC_W-1:0]  out_acc_reg;
    logic signed [ACC_W-1:0]  out_acc_next;
    logic                     out_motion_reg;
    logic                     out_motion_next;

    logic [COUNT_BITS-1:0]    in_count_a;
    logic [COUNT_BITS-1:0]    in_count_b;
    logic [COUNT_BITS-1:0]    in_count_c;
    logic [INTERVAL_BITS-1:0] in_int_a;
    logic [INTERVAL_BITS-1:0] in_int_b;
    logic [INTERVAL_BITS-1:0] in_int_c;
    logic                     eq_ab;
    logic                     eq_ac;
    logic                     eq_bc;
    vote_status_t             vote_status;
    logic [COUNT_BITS-1:0]    vote_count;
    logic [SUM_W-1:0]         vote_sum;

    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic [PROD_W-1:0]        prod;
    logic [CNT_EXT_W-1:0]     count_ext;
    logic signed [ACC_W-1:0]  vel_diff;
    logic [ACC_W-1:0]         vel_mag;
    logic signed [ACC_W-1:0]  quo_ext;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign in_count_a = s_tdata[COUNT_BITS-1:0];
    assign in_count_b = s_tdata[2*COUNT_BITS-1:COUNT_BITS];
    assign in_count_c = s_tdata[3*COUNT_BITS-1:2*COUNT_BITS];
    assign in_int_a   = s_tdata[IN_INT_OFS+INTERVAL_BITS-1:IN_INT_OFS];
    assign in_int_b   = s_tdata[IN_INT_OFS+2*INTERVAL_BITS-1:IN_INT_OFS+INTERVAL_BITS];
    assign in_int_c   = s_tdata[IN_INT_OFS+3*INTERVAL_BITS-1:IN_INT_OFS+2*INTERVAL_BITS];

    assign eq_ab = in_count_a == in_count_b;
    assign eq_ac = in_count_a == in_count_c;
    assign eq_bc = in_count_b == in_count_c;

    always_comb
    begin
        vote_status = VOTE_NONE;
        vote_count  = '0;
        vote_sum    = '0;
        if (eq_ab && eq_ac)
        begin
            vote_status = VOTE_ALL;
            vote_count  = in_count_a;
            vote_sum    = SUM_W'(in_int_a) + SUM_W'(in_int_b) + SUM_W'(in_int_c);
        end
        else if (eq_ab)
        begin
            vote_status = VOTE_OUT_C;
            vote_count  = in_count_a;
            vote_sum    = SUM_W'(in_int_a) + SUM_W'(in_int_b);
        end
        else if (eq_ac)
        begin
            vote_status = VOTE_OUT_B;
            vote_count  = in_count_a;
            vote_sum    = SUM_W'(in_int_a) + SUM_W'(in_int_c);
        end
        else if (eq_bc)
        begin
            vote_status = VOTE_OUT_A;
            vote_count  = in_count_b;
            vote_sum    = SUM_W'(in_int_b) + SUM_W'(in_int_c);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_POS:
            begin
                mul_a = MA_W'(count_reg);
                mul_b = MB_W'(spacing_reg);
            end
            ST_MUL_AVG:
            begin
                mul_a = MA_W'(sum_reg);
                mul_b = MB_W'(RECIP3);
            end
            ST_MUL_VEL:
            begin
                mul_a = MA_W'(spacing_reg);
                mul_b = MB_W'(MS_PER_S);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign count_ext = CNT_EXT_W'(count_reg);
    assign vel_diff  = signed'({1'b0, last_vel_reg}) - signed'({1'b0, vel_reg});
    assign vel_mag   = vel_diff[ACC_W-1] ? ACC_W'(-vel_diff) : ACC_W'(vel_diff);
    assign quo_ext   = signed'({1'b0, div_rsp.quotient});

    always_comb
    begin
        state_next      = state_reg;
        last_vel_next   = last_vel_reg;
        m_tvalid_next   = m_tvalid_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        sum_next        = sum_reg;
        interval_next   = interval_reg;
        pos_next        = pos_reg;
        vel_next        = vel_reg;
        acc_next        = acc_reg;
        motion_next     = motion_reg;
        neg_next        = neg_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_vel_next    = out_vel_reg;
        out_acc_next    = out_acc_reg;
        out_motion_next = out_motion_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod[VEL_W-1:0];
        div_req.divisor  = interval_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    status_next   = vote_status;
                    count_next    = vote_count;
                    sum_next      = vote_sum;
                    interval_next = INTERVAL_BITS'(vote_sum >> 1);
                    vel_next      = '0;
                    acc_next      = '0;
                    motion_next   = 1'b0;
                    state_next    = ST_MUL_POS;
                end
            end
            ST_MUL_POS:
            begin
                pos_next = prod[POS_W-1:0];
                if (status_reg == VOTE_NONE)
                begin
                    state_next = ST_OUT;
                end
                else if (status_reg == VOTE_ALL)
                begin
                    state_next = ST_MUL_AVG;
                end
                else
                begin
                    state_next = ST_MUL_VEL;
                end
            end
            ST_MUL_AVG:
            begin
                interval_next = INTERVAL_BITS'(prod >> RECIP3_SHIFT);
                state_next    = ST_MUL_VEL;
            end
            ST_MUL_VEL:
            begin
                if (interval_reg != '0)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_VEL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_VEL:
            begin
                if (div_rsp.done)
                begin
                    vel_next   = div_rsp.quotient;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = vel_mag[VEL_W-1:0];
                neg_next         = vel_diff[ACC_W-1];
                state_next       = ST_DIV_ACC;
            end
            ST_DIV_ACC:
            begin
                if (div_rsp.done)
                begin
                    acc_next      = neg_reg ? -quo_ext : quo_ext;
                    motion_next   = 1'b1;
                    last_vel_next = vel_reg;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_count_next  = count_ext[AGREED_W-1:0];
                    out_status_next = status_reg;
                    out_pos_next    = pos_reg;
                    out_vel_next    = vel_reg;
                    out_acc_next    = acc_reg;
                    out_motion_next = motion_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            spacing_reg  <= SPACING_RESET;
            last_vel_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_vel_reg <= last_vel_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                spacing_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        status_reg     <= status_next;
        sum_reg        <= sum_next;
        interval_reg   <= interval_next;
        pos_reg        <= pos_next;
        vel_reg        <= vel_next;
        acc_reg        <= acc_next;
        motion_reg     <= motion_next;
        neg_reg        <= neg_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_vel_reg    <= out_vel_next;
        out_acc_reg    <= out_acc_next;
        out_motion_reg <= out_motion_next;
    end

    vso_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({out_acc_reg, out_vel_reg, out_pos_reg, out_count_reg});
    assign m_tuser  = {out_motion_reg, out_status_reg};

    `VSO_ASSERT_NOW(a_div_nonzero, div_req.start, div_req.divisor != '0, "divider started with a zero divisor")
    `VSO_ASSERT_NOW(a_done_expected, div_rsp.done, (state_reg == ST_DIV_VEL) || (state_reg == ST_DIV_ACC), "divider finished outside a wait state")
    `VSO_ASSERT_NOW(a_motion_voted, m_tvalid && m_tuser[STATUS_W], m_tuser[STATUS_W-1:0] != VOTE_NONE, "motion reported without agreement")
    `VSO_ASSERT_NOW(a_none_zero, m_tvalid && (m_tuser[STATUS_W-1:0] == VOTE_NONE), (out_count_reg == '0) && (out_pos_reg == '0), "count or position set without agreement")
    `VSO_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while the previous one is in work")

endmodule
